### hdl/lrr_pkg.sv
// ----------------------------------------------------------------------------
// lrr_pkg
// Shared widths, command codes and controller/datapath link types for the
// level round-robin server picker.
// ----------------------------------------------------------------------------
package lrr_pkg;

    // Widths of the item fields at the ports
    localparam int ACTION_W   = 3;
    localparam int IDX_IN_W   = 4;
    localparam int LEVEL_IN_W = 4;
    localparam int CONN_IN_W  = 16;
    localparam int POLICY_W   = 2;

    // Command codes carried by the action field
    typedef enum logic [ACTION_W-1:0] {
        ACT_WRITE        = 3'd0,
        ACT_SET_CONNS    = 3'd1,
        ACT_PICK_PRIMARY = 3'd2,
        ACT_PICK_BACKUP  = 3'd3,
        ACT_CLEAR_POS    = 3'd4
    } t_action;

    // Entry policies; the remaining codes behave as balance
    localparam logic [POLICY_W-1:0] POL_SINGLE  = 2'd0;
    localparam logic [POLICY_W-1:0] POL_BACKUP  = 2'd1;
    localparam logic [POLICY_W-1:0] POL_BALANCE = 2'd2;

    // Source of the entry table read address
    typedef enum logic [1:0] {
        RD_NAMED,
        RD_PRIM,
        RD_SCAN
    } t_rd_sel;

    // Source of the result
    typedef enum logic [1:0] {
        RES_NONE,
        RES_NAMED,
        RES_SCAN
    } t_res_sel;

    // Controller to datapath
    typedef struct packed {
        logic     latch_item;
        logic     do_write;
        logic     do_set;
        logic     do_clear;
        t_rd_sel  rd_sel;
        logic     lv_load;
        logic     scan_start;
        logic     scan_count;
        logic     scan_pick;
        logic     want_load;
        logic     pos_write;
        logic     res_set;
        t_res_sel res_sel;
        logic     out_load;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                idx_ok;
        logic                prim_ok;
        logic                rd_valid;
        logic [POLICY_W-1:0] rd_policy;
        logic                rd_at_limit;
        logic                count_done;
        logic                count_zero;
        logic                scan_hit;
        logic                scan_last;
    } t_dp_sts;

endpackage

### hdl/lrr_datapath.sv
// ----------------------------------------------------------------------------
// lrr_datapath
// Entry table, per-level rotation positions, the scan pipeline that counts
// and walks the entries of one level, and the result registers.
// ----------------------------------------------------------------------------
module lrr_datapath import lrr_pkg::*; #(
    parameter int ENTRIES   = 16,
    parameter int LEVELS    = 16,
    parameter int CONN_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [ACTION_W-1:0]   i_action,
    input  logic [IDX_IN_W-1:0]   i_entry_index,
    input  logic [LEVEL_IN_W-1:0] i_group_level,
    input  logic [CONN_IN_W-1:0]  i_conn_limit,
    input  logic [POLICY_W-1:0]   i_policy_code,
    input  logic [CONN_IN_W-1:0]  i_conn_count,
    input  logic [IDX_IN_W-1:0]   i_primary_index,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    output logic                  o_found,
    output logic [IDX_IN_W-1:0]   o_chosen_index
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    // Latched item
    logic [ACTION_W-1:0]   r_item_action;
    logic [IDX_IN_W-1:0]   r_item_idx;
    logic [LEVEL_IN_W-1:0] r_item_level;
    logic [CONN_IN_W-1:0]  r_item_limit;
    logic [POLICY_W-1:0]   r_item_policy;
    logic [CONN_IN_W-1:0]  r_item_count;
    logic [IDX_IN_W-1:0]   r_item_prim;

    // Entry table and positions
    logic [LVL_W-1:0]     r_mem_level  [ENTRIES];
    logic [CONN_BITS-1:0] r_mem_limit  [ENTRIES];
    logic [CONN_BITS-1:0] r_mem_conns  [ENTRIES];
    logic [POLICY_W-1:0]  r_mem_policy [ENTRIES];
    logic [IDX_W-1:0]     r_mem_pos    [LEVELS];
    logic [ENTRIES-1:0]   r_ent_valid;
    logic [ENTRIES-1:0]   r_conn_set;
    logic [LEVELS-1:0]    r_pos_set;

    // Registered read data
    logic [LVL_W-1:0]     r_rd_level;
    logic [CONN_BITS-1:0] r_rd_limit;
    logic [CONN_BITS-1:0] r_rd_conns_raw;
    logic [POLICY_W-1:0]  r_rd_policy;
    logic                 r_rd_valid;
    logic                 r_rd_conn_set;
    logic [IDX_W-1:0]     r_rd_pos;
    logic                 r_rd_pos_set;

    // Scan state
    logic [LVL_W-1:0] r_lv;
    logic [IDX_W-1:0] r_scan_addr;
    logic             r_eval_vld;
    logic [IDX_W-1:0] r_eval_idx;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_seen;
    logic [CNT_W-1:0] r_tries;
    logic [IDX_W-1:0] r_want;
    logic [IDX_W-1:0] r_pos_cur;
    logic             r_lap;

    // Result and output
    logic                r_res_found;
    logic [IDX_IN_W-1:0] r_res_idx;
    logic                r_out_found;
    logic [IDX_IN_W-1:0] r_out_idx;

    logic                 idx_ok;
    logic                 prim_ok;
    logic [IDX_W-1:0]     item_addr;
    logic [IDX_W-1:0]     prim_addr;
    logic [IDX_W-1:0]     rd_addr;
    logic [LVL_W-1:0]     item_lvl;
    logic [CONN_BITS-1:0] rd_conns;
    logic                 rd_at_limit;
    logic                 match;
    logic                 consider;
    logic                 scan_hit;
    logic                 scan_last;
    logic [IDX_W-1:0]     pos_next;
    logic [IDX_W-1:0]     want_val;

    // Decode the latched item
    assign idx_ok    = (32'(r_item_idx) < ENTRIES);
    assign prim_ok   = (32'(r_item_prim) < ENTRIES);
    assign item_addr = IDX_W'(r_item_idx);
    assign prim_addr = IDX_W'(r_item_prim);
    assign item_lvl  = (32'(r_item_level) >= LEVELS) ? LVL_W'(LEVELS - 1)
                                                      : LVL_W'(r_item_level);

    // Pick the table read address
    always_comb begin
        case (i_cmd.rd_sel)
            RD_NAMED: rd_addr = item_addr;
            RD_PRIM:  rd_addr = prim_addr;
            RD_SCAN:  rd_addr = r_scan_addr;
            default:  rd_addr = item_addr;
        endcase
    end

    // Limit test and scan decisions on the entry under evaluation
    assign rd_conns    = r_rd_conn_set ? r_rd_conns_raw : '0;
    assign rd_at_limit = (r_rd_limit != '0) && (rd_conns >= r_rd_limit);
    assign match       = r_eval_vld && r_rd_valid && (r_rd_level == r_lv);
    assign consider    = match && (r_lap || (r_seen >= CNT_W'(r_want)));
    assign scan_hit    = consider && !rd_at_limit;
    assign scan_last   = consider && (CNT_W'(r_tries + CNT_W'(1)) == r_count);
    assign pos_next    = (CNT_W'(r_pos_cur) + CNT_W'(1) >= r_count) ? '0
                                                                   : r_pos_cur + IDX_W'(1);
    assign want_val    = (r_rd_pos_set && (CNT_W'(r_rd_pos) < r_count)) ? r_rd_pos : '0;

    // Latch the accepted item
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_item) begin
            r_item_action <= i_action;
            r_item_idx    <= i_entry_index;
            r_item_level  <= i_group_level;
            r_item_limit  <= i_conn_limit;
            r_item_policy <= i_policy_code;
            r_item_count  <= i_conn_count;
            r_item_prim   <= i_primary_index;
        end
    end

    // Write and read the table memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_write && idx_ok) begin
            r_mem_level[item_addr]  <= item_lvl;
            r_mem_limit[item_addr]  <= CONN_BITS'(r_item_limit);
            r_mem_policy[item_addr] <= r_item_policy;
        end
        if (i_cmd.do_set && idx_ok) begin
            r_mem_conns[item_addr] <= CONN_BITS'(r_item_count);
        end
        if (i_cmd.pos_write) begin
            r_mem_pos[r_lv] <= pos_next;
        end
        r_rd_level     <= r_mem_level[rd_addr];
        r_rd_limit     <= r_mem_limit[rd_addr];
        r_rd_conns_raw <= r_mem_conns[rd_addr];
        r_rd_policy    <= r_mem_policy[rd_addr];
        r_rd_pos       <= r_mem_pos[r_lv];
    end

    // Hold the valid bits; a position not yet written reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_valid   <= '0;
            r_conn_set    <= '0;
            r_pos_set     <= '0;
            r_rd_valid    <= 1'b0;
            r_rd_conn_set <= 1'b0;
            r_rd_pos_set  <= 1'b0;
        end else begin
            if (i_cmd.do_write && idx_ok) begin
                r_ent_valid[item_addr] <= 1'b1;
            end
            if (i_cmd.do_set && idx_ok) begin
                r_conn_set[item_addr] <= 1'b1;
            end
            if (i_cmd.do_clear) begin
                r_pos_set <= '0;
            end else if (i_cmd.pos_write) begin
                r_pos_set[r_lv] <= 1'b1;
            end
            r_rd_valid    <= r_ent_valid[rd_addr];
            r_rd_conn_set <= r_conn_set[rd_addr];
            r_rd_pos_set  <= r_pos_set[r_lv];
        end
    end

    // Level under rotation
    always_ff @(posedge i_clk) begin
        if (i_cmd.lv_load) begin
            r_lv <= r_rd_level;
        end
    end

    // Walk the entries, count the level, then try them from the position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_addr <= '0;
            r_eval_vld  <= 1'b0;
            r_eval_idx  <= '0;
            r_count     <= '0;
            r_seen      <= '0;
            r_tries     <= '0;
            r_want      <= '0;
            r_pos_cur   <= '0;
            r_lap       <= 1'b0;
        end else begin
            if (i_cmd.scan_start) begin
                r_scan_addr <= '0;
                r_eval_vld  <= 1'b0;
                r_seen      <= '0;
                r_tries     <= '0;
                r_lap       <= 1'b0;
            end else if (i_cmd.scan_count || i_cmd.scan_pick) begin
                r_scan_addr <= (r_scan_addr == LAST_IDX) ? '0 : r_scan_addr + IDX_W'(1);
                r_eval_vld  <= 1'b1;
                r_eval_idx  <= r_scan_addr;
            end
            if (i_cmd.lv_load) begin
                r_count <= '0;
            end else if (i_cmd.scan_count && match) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.scan_pick && r_eval_vld) begin
                if (match && !r_lap) begin
                    r_seen <= r_seen + CNT_W'(1);
                end
                if (r_eval_idx == LAST_IDX) begin
                    r_lap <= 1'b1;
                end
                if (consider) begin
                    r_tries   <= r_tries + CNT_W'(1);
                    r_pos_cur <= pos_next;
                end
            end
            if (i_cmd.want_load) begin
                r_want    <= want_val;
                r_pos_cur <= want_val;
            end
        end
    end

    // Build the result, then move it to the output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_set) begin
            case (i_cmd.res_sel)
                RES_NAMED: begin
                    r_res_found <= 1'b1;
                    r_res_idx   <= r_item_idx;
                end
                RES_SCAN: begin
                    r_res_found <= 1'b1;
                    r_res_idx   <= IDX_IN_W'(r_eval_idx);
                end
                default: begin
                    r_res_found <= 1'b0;
                    r_res_idx   <= '0;
                end
            endcase
        end
        if (i_cmd.out_load) begin
            r_out_found <= r_res_found;
            r_out_idx   <= r_res_idx;
        end
    end

    assign o_found        = r_out_found;
    assign o_chosen_index = r_out_idx;

    // Status to the controller
    always_comb begin
        o_sts.action      = r_item_action;
        o_sts.idx_ok      = idx_ok;
        o_sts.prim_ok     = prim_ok;
        o_sts.rd_valid    = r_rd_valid;
        o_sts.rd_policy   = r_rd_policy;
        o_sts.rd_at_limit = rd_at_limit;
        o_sts.count_done  = r_eval_vld && (r_eval_idx == LAST_IDX);
        o_sts.count_zero  = (r_count == '0);
        o_sts.scan_hit    = scan_hit;
        o_sts.scan_last   = scan_last;
    end

    // A try never runs past the number of entries at the level
    a_tries_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_pick |-> (r_tries < r_count))
        else $error("rotation tries reached the level count while scanning");

    // The start position lies inside the level
    a_want_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_pick |-> (CNT_W'(r_want) < r_count))
        else $error("rotation start position outside the level");

endmodule

### hdl/lrr_ctrl.sv
// ----------------------------------------------------------------------------
// lrr_ctrl
// Sequencer for one command at a time: decode, named and primary lookups,
// the count pass, the rotation pass and the result hand-off.
// ----------------------------------------------------------------------------
module lrr_ctrl import lrr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    output logic    o_valid,
    input  logic    i_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_NAMED,
        S_PRIM,
        S_COUNT,
        S_WANT,
        S_SCAN,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_vld;
    logic   n_out_vld;

    // Next state, next output valid and datapath commands
    always_comb begin
        o_cmd     = '0;
        n_state   = r_state;
        n_out_vld = r_out_vld;
        if (r_out_vld && !i_stall) begin
            n_out_vld = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.latch_item = 1'b1;
                    n_state          = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                o_cmd.rd_sel = RD_NAMED;
                unique case (i_sts.action) inside
                    ACT_WRITE: begin
                        o_cmd.do_write = 1'b1;
                        o_cmd.res_set  = 1'b1;
                        o_cmd.res_sel  = RES_NONE;
                        n_state        = S_DONE;
                    end
                    ACT_SET_CONNS: begin
                        o_cmd.do_set  = 1'b1;
                        o_cmd.res_set = 1'b1;
                        o_cmd.res_sel = RES_NONE;
                        n_state       = S_DONE;
                    end
                    ACT_CLEAR_POS: begin
                        o_cmd.do_clear = 1'b1;
                        o_cmd.res_set  = 1'b1;
                        o_cmd.res_sel  = RES_NONE;
                        n_state        = S_DONE;
                    end
                    ACT_PICK_PRIMARY, ACT_PICK_BACKUP: begin
                        n_state = S_NAMED;
                    end
                    default: begin
                        o_cmd.res_set = 1'b1;
                        o_cmd.res_sel = RES_NONE;
                        n_state       = S_DONE;
                    end
                endcase
            end
            S_NAMED: begin
                // fetch the primary entry in case the backup path needs it
                o_cmd.rd_sel = RD_PRIM;
                if (i_sts.action == ACT_PICK_PRIMARY) begin
                    if (!(i_sts.idx_ok && i_sts.rd_valid)) begin
                        o_cmd.res_set = 1'b1;
                        o_cmd.res_sel = RES_NONE;
                        n_state       = S_DONE;
                    end else if (i_sts.rd_policy == POL_BACKUP && i_sts.rd_at_limit) begin
                        o_cmd.lv_load    = 1'b1;
                        o_cmd.scan_start = 1'b1;
                        n_state          = S_COUNT;
                    end else if (i_sts.rd_policy == POL_SINGLE ||
                                 i_sts.rd_policy == POL_BACKUP) begin
                        o_cmd.res_set = 1'b1;
                        o_cmd.res_sel = RES_NAMED;
                        n_state       = S_DONE;
                    end else begin
                        o_cmd.lv_load    = 1'b1;
                        o_cmd.scan_start = 1'b1;
                        n_state          = S_COUNT;
                    end
                end else begin
                    if (!(i_sts.idx_ok && i_sts.rd_valid) ||
                        i_sts.rd_policy == POL_SINGLE) begin
                        o_cmd.res_set = 1'b1;
                        o_cmd.res_sel = RES_NONE;
                        n_state       = S_DONE;
                    end else begin
                        n_state = S_PRIM;
                    end
                end
            end
            S_PRIM: begin
                if (i_sts.prim_ok && i_sts.rd_valid) begin
                    o_cmd.lv_load    = 1'b1;
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_COUNT;
                end else begin
                    o_cmd.res_set = 1'b1;
                    o_cmd.res_sel = RES_NONE;
                    n_state       = S_DONE;
                end
            end
            S_COUNT: begin
                o_cmd.rd_sel     = RD_SCAN;
                o_cmd.scan_count = 1'b1;
                if (i_sts.count_done) begin
                    n_state = S_WANT;
                end
            end
            S_WANT: begin
                if (i_sts.count_zero) begin
                    o_cmd.res_set = 1'b1;
                    o_cmd.res_sel = RES_NONE;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.want_load  = 1'b1;
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.rd_sel    = RD_SCAN;
                o_cmd.scan_pick = 1'b1;
                if (i_sts.scan_hit) begin
                    o_cmd.pos_write = 1'b1;
                    o_cmd.res_set   = 1'b1;
                    o_cmd.res_sel   = RES_SCAN;
                    n_state         = S_DONE;
                end else if (i_sts.scan_last) begin
                    o_cmd.pos_write = 1'b1;
                    o_cmd.res_set   = 1'b1;
                    o_cmd.res_sel   = RES_NONE;
                    n_state         = S_DONE;
                end
            end
            S_DONE: begin
                // hand over once the output register is free
                if (!r_out_vld || !i_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_out_vld      = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_vld;

    // An accepted item always starts with its decode
    a_accept_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == S_DISPATCH))
        else $error("accepted item did not reach decode");

    // A result appears only at the end of a command
    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_DONE))
        else $error("result raised outside the hand-off state");

    // A finished result waits while the previous one is still held
    a_done_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && o_valid && i_stall) |=> (r_state == S_DONE && o_valid))
        else $error("result overwritten while the output was stalled");

endmodule

### hdl/level_round_robin_server_picker_core.sv
// ----------------------------------------------------------------------------
// level_round_robin_server_picker_core
// Backend table with per-level round-robin selection under connection limits.
// ----------------------------------------------------------------------------
// One command is in flight at a time. Write entry, set connections, clear
// positions and unknown actions pass through decode and the hand-off state;
// a pick answered by the named entry also passes the named lookup. A pick that
// rotates reads the entry table one entry per cycle through its single read
// port: one pass counts the entries of the level, and a second walk finds the
// entry at the rotating position and tries the following ones until one is
// below its limit or every entry of the level has been tried. Every command
// returns exactly one result item; the next item is taken while a finished
// result still waits in the output register.
// ----------------------------------------------------------------------------
module level_round_robin_server_picker_core import lrr_pkg::*; #(
    parameter int ENTRIES   = 16,
    parameter int LEVELS    = 16,
    parameter int CONN_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [ACTION_W-1:0]   i_action,
    input  logic [IDX_IN_W-1:0]   i_entry_index,
    input  logic [LEVEL_IN_W-1:0] i_group_level,
    input  logic [CONN_IN_W-1:0]  i_conn_limit,
    input  logic [POLICY_W-1:0]   i_policy_code,
    input  logic [CONN_IN_W-1:0]  i_conn_count,
    input  logic [IDX_IN_W-1:0]   i_primary_index,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_found,
    output logic [IDX_IN_W-1:0]   o_chosen_index
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Command sequencer
    lrr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Table, scan pipeline and result registers
    lrr_datapath #(
        .ENTRIES   (ENTRIES),
        .LEVELS    (LEVELS),
        .CONN_BITS (CONN_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_action        (i_action),
        .i_entry_index   (i_entry_index),
        .i_group_level   (i_group_level),
        .i_conn_limit    (i_conn_limit),
        .i_policy_code   (i_policy_code),
        .i_conn_count    (i_conn_count),
        .i_primary_index (i_primary_index),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_found         (o_found),
        .o_chosen_index  (o_chosen_index)
    );

endmodule
